// ===== rtl/vt4_pkg.sv =====
// Shared types and constants for the 4x4 vertex transform unit.
package vt4_pkg;

    // Width of one vector component or matrix element, signed fixed point.
    localparam int DATA_W      = 32;
    // Number of vector components and of matrix rows and columns.
    localparam int NUM_COMP    = 4;
    // Matrix configuration registers, two elements each.
    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    // Stream payload width: four packed components.
    localparam int VEC_W       = NUM_COMP * DATA_W;
    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    // Widths of the exact product and of the partial sums.
    localparam int PROD_W      = 2 * DATA_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;

    // One classified vertex, ready for the arithmetic back end.
    typedef struct packed {
        logic                     point;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] w;
    } vt4_item_t;

    // Queue status as seen by the back end.
    typedef struct packed {
        logic      valid;
        vt4_item_t item;
    } vt4_qhead_t;

endpackage

// ===== rtl/vt4_front.sv =====
// Input stage: accepts vertices and classifies them as full vectors or points.
module vt4_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [vt4_pkg::VEC_W-1:0] s_tdata,
    input  logic                     s_tuser,
    output logic                     push_valid,
    output vt4_pkg::vt4_item_t       push_item,
    input  logic                     q_full
);
    import vt4_pkg::*;

    localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

    logic      front_valid_reg;
    logic      front_valid_next;
    vt4_item_t item_reg;
    vt4_item_t item_next;
    logic      accept;
    logic      push;

    // The stage takes a new vertex when it is empty or drains this cycle.
    assign s_tready = !front_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = front_valid_reg && !q_full;

    // A point takes w as one; a full vector keeps its own w.
    always_comb
    begin
        item_next.point = s_tuser;
        item_next.x     = s_tdata[DATA_W-1:0];
        item_next.y     = s_tdata[2*DATA_W-1:DATA_W];
        item_next.z     = s_tdata[3*DATA_W-1:2*DATA_W];
        item_next.w     = s_tuser ? ONE_FX : s_tdata[4*DATA_W-1:3*DATA_W];
    end

    always_comb
    begin
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

endmodule

// ===== rtl/vt4_queue.sv =====
// Short first-in first-out queue that decouples the front from the back.
module vt4_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  vt4_pkg::vt4_item_t push_item,
    output logic               full,
    input  logic               pop,
    output vt4_pkg::vt4_qhead_t head
);
    import vt4_pkg::*;

    vt4_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push_valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/vt4_back.sv =====
// Arithmetic back end: matrix registers, product stage, two adder stages with saturation.
module vt4_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vt4_pkg::vt4_qhead_t           head,
    output logic                          pop,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vt4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vt4_pkg::VEC_W-1:0]      m_tdata,
    output logic                          m_tuser
);
    import vt4_pkg::*;

    localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (FRAC_BITS + DATA_W);

    // Matrix registers, column-major, two rows per register.
    logic [CFG_DATA_W-1:0]    mat_reg [NUM_REGS];
    logic signed [DATA_W-1:0] elem [NUM_COMP][NUM_COMP];
    logic signed [DATA_W-1:0] vec [NUM_COMP];

    // Pipeline registers.
    logic                     p1_valid_reg;
    logic                     p1_valid_next;
    logic                     p1_point_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_COMP][NUM_COMP];
    logic                     p2_valid_reg;
    logic                     p2_valid_next;
    logic                     p2_point_reg;
    logic signed [PAIR_W-1:0] pair_reg [NUM_COMP][2];
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [VEC_W-1:0]         out_data_reg;
    logic [VEC_W-1:0]         out_data_next;
    logic                     out_sat_reg;
    logic                     out_sat_next;

    logic                     load1;
    logic                     load2;
    logic                     load3;
    logic signed [SUM_W-1:0]  total [NUM_COMP];
    logic signed [SUM_W-1:0]  shifted [NUM_COMP];
    logic [NUM_COMP-1:0]      row_sat;
    logic [DATA_W-1:0]        row_val [NUM_COMP];

    // Configuration writes are always taken; indexes past the last register are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE_LO;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE_HI;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE_LO;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE_HI;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Element of row r and column c lives in register 2c + r/2, half r%2.
    always_comb
    begin
        for (int r = 0; r < NUM_COMP; r++)
        begin
            for (int c = 0; c < NUM_COMP; c++)
            begin
                elem[r][c] = mat_reg[2 * c + r / 2][DATA_W * (r % 2) +: DATA_W];
            end
        end
        vec[0] = head.item.x;
        vec[1] = head.item.y;
        vec[2] = head.item.z;
        vec[3] = head.item.w;
    end

    // Stage advance: each stage loads when empty or when the stage after it moves.
    assign load3 = !out_valid_reg || m_tready;
    assign load2 = !p2_valid_reg || load3;
    assign load1 = !p1_valid_reg || load2;
    assign pop   = head.valid && load1;

    always_comb
    begin
        p1_valid_next  = load1 ? head.valid : p1_valid_reg;
        p2_valid_next  = load2 ? p1_valid_reg : p2_valid_reg;
        out_valid_next = load3 ? p2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage one: sixteen exact products.
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            p1_point_reg <= head.item.point;
            for (int r = 0; r < NUM_COMP; r++)
            begin
                for (int c = 0; c < NUM_COMP; c++)
                begin
                    prod_reg[r][c] <= PROD_W'(elem[r][c]) * PROD_W'(vec[c]);
                end
            end
        end
    end

    // Stage two: pairwise sums per row.
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            p2_point_reg <= p1_point_reg;
            for (int r = 0; r < NUM_COMP; r++)
            begin
                pair_reg[r][0] <= PAIR_W'(prod_reg[r][0]) + PAIR_W'(prod_reg[r][1]);
                pair_reg[r][1] <= PAIR_W'(prod_reg[r][2]) + PAIR_W'(prod_reg[r][3]);
            end
        end
    end

    // Stage three: row total, floor shift by the fraction width, clamp to 32 bits.
    always_comb
    begin
        for (int r = 0; r < NUM_COMP; r++)
        begin
            total[r]   = SUM_W'(pair_reg[r][0]) + SUM_W'(pair_reg[r][1]);
            shifted[r] = total[r] >>> FRAC_BITS;
            if (!shifted[r][SUM_W-1] && (|shifted[r][SUM_W-2:DATA_W-1]))
            begin
                row_sat[r] = 1'b1;
                row_val[r] = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else if (shifted[r][SUM_W-1] && !(&shifted[r][SUM_W-2:DATA_W-1]))
            begin
                row_sat[r] = 1'b1;
                row_val[r] = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                row_sat[r] = 1'b0;
                row_val[r] = shifted[r][DATA_W-1:0];
            end
        end
        // A point has no w result and its w row never counts as clamped.
        out_data_next = {p2_point_reg ? {DATA_W{1'b0}} : row_val[3],
                         row_val[2], row_val[1], row_val[0]};
        out_sat_next  = row_sat[0] || row_sat[1] || row_sat[2] ||
                        (row_sat[3] && !p2_point_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ===== rtl/vertex_transform_4x4_unit.sv =====
// Top level of the 4x4 vertex transform unit.
//
// Multiplies each vertex by a column-major 4x4 signed fixed-point matrix.
// Input stream (s_*): s_tdata carries x, y, z, w from bit 0 up, 32 bits each;
// s_tuser selects the kind: 0 for a full vector, 1 for a point with w as one.
// Output stream (m_*): m_tdata carries x, y, z, w from bit 0 up; m_tuser is
// set when any computed row was clamped. For a point, output w is zero.
// Configuration channel: cfg_index selects one of the eight matrix registers,
// cfg_data holds two elements (low half the first row); it is always ready,
// and indexes beyond seven are ignored. Write only while the unit is idle.
// Throughput: one vertex per cycle while the receiver keeps m_tready high,
// set by the single pass of each vertex through the sixteen parallel
// multipliers. A result is offered after passing the input register, queue,
// product stage, adder stage and clamp into the output register.
// Reset loads the identity matrix and empties all stages; no clearing pass.
// When the receiver stalls, the back pipeline holds, the four-entry queue
// fills, and s_tready drops only once the queue and input register are full.
module vertex_transform_4x4_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input vertex: s_tdata = in_x, in_y, in_z, in_w; s_tuser = mode.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vt4_pkg::VEC_W-1:0]      s_tdata,
    input  logic                          s_tuser,
    // Result: m_tdata = out_x, out_y, out_z, out_w; m_tuser = saturated.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vt4_pkg::VEC_W-1:0]      m_tdata,
    output logic                          m_tuser,
    // Matrix register writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vt4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vt4_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vt4_pkg::*;

    logic       push_valid;
    vt4_item_t  push_item;
    logic       q_full;
    logic       q_pop;
    vt4_qhead_t q_head;

    vt4_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    vt4_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    vt4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/tb_vertex_transform_4x4_unit.sv =====
// Self-checking stream testbench for the 4x4 vertex transform unit.
`timescale 1ns / 1ps

module tb_vertex_transform_4x4_unit;
    import vt4_pkg::*;

    localparam int FRAC              = 16;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int RESET_CYCLES      = 11;
    localparam int DRAIN_CYCLES      = 8;
    localparam int RANDOM_SEGMENTS   = 6;
    localparam int ITEMS_PER_SEGMENT = 108;

    // Vertex kinds carried on s_tuser.
    localparam logic MODE_VEC4  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    // Matrix register indexes; anything past the last one is ignored.
    localparam logic [CFG_IDX_W-1:0] REG_COL0_XY     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL0_ZW     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL1_XY     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL1_ZW     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL2_XY     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL2_ZW     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COL3_XY     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COL3_ZW     = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    // Fixed-point values of interest.
    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE  = 32'd1 << FRAC;
    localparam logic [DATA_W-1:0] Q_HALF = 32'd1 << (FRAC - 1);
    localparam logic [DATA_W-1:0] Q_ULP  = 32'd1;

    // Clamp bounds for a shifted row sum.
    localparam logic signed [SUM_W-1:0] ROW_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] ROW_MIN = -ROW_MAX - 1;

    typedef struct packed {
        logic                             mode;
        logic [NUM_COMP-1:0][DATA_W-1:0]  comp;
    } vertex_t;

    typedef struct packed {
        logic                             sat;
        logic [NUM_COMP-1:0][DATA_W-1:0]  comp;
    } xform_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    // x, y, z, w from bit 0 up, 32 bits each.
    logic [VEC_W-1:0]        s_tdata   = '0;
    // mode.
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // out_x, out_y, out_z, out_w from bit 0 up, 32 bits each.
    logic [VEC_W-1:0]        m_tdata;
    // saturated.
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // Testbench copy of the matrix, updated on each register transaction to a mapped index.
    logic [CFG_DATA_W-1:0]   matrix_regs [NUM_REGS];
    vertex_t                 vertex_queue [$];
    xform_t                  expected_xforms [$];
    string                   comp_names [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int accepted_count = 0;
    int sat_count = 0;
    int cfg_write_count = 0;
    int cycle_count = 0;

    vertex_transform_4x4_unit #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Row sums are kept exact at 66 bits, floored by the arithmetic shift,
    // then clamped. A point takes w as one and leaves out_w at zero.
    function automatic xform_t transform_vertex(vertex_t v);
        logic signed [DATA_W-1:0] operand [NUM_COMP];
        logic signed [DATA_W-1:0] element;
        logic signed [SUM_W-1:0]  row_sum;
        logic [CFG_DATA_W-1:0]    reg_word;
        xform_t                   res;
        res = '0;
        for (int k = 0; k < NUM_COMP; k++)
            operand[k] = v.comp[k];
        if (v.mode == MODE_POINT)
            operand[NUM_COMP-1] = Q_ONE;
        for (int row = 0; row < NUM_COMP; row++)
        begin
            if (!(v.mode == MODE_POINT && row == NUM_COMP - 1))
            begin
                row_sum = '0;
                for (int col = 0; col < NUM_COMP; col++)
                begin
                    reg_word = matrix_regs[col * 2 + row / 2];
                    element = (row % 2) ? reg_word[2*DATA_W-1:DATA_W] : reg_word[DATA_W-1:0];
                    row_sum = row_sum + element * operand[col];
                end
                row_sum = row_sum >>> FRAC;
                if (row_sum > ROW_MAX)
                begin
                    res.sat = 1'b1;
                    res.comp[row] = Q_MAX;
                end
                else if (row_sum < ROW_MIN)
                begin
                    res.sat = 1'b1;
                    res.comp[row] = Q_MIN;
                end
                else
                begin
                    res.comp[row] = row_sum[DATA_W-1:0];
                end
            end
        end
        return res;
    endfunction

    // Vector component: extremes, zero, small magnitudes and full range.
    function automatic logic [DATA_W-1:0] rand_component();
        logic [DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return {{12{r[19]}}, r[19:0]};
            4: return '0;
            default: return r;
        endcase
    endfunction

    // Matrix element drawn according to the style of the current setting.
    function automatic logic [DATA_W-1:0] rand_element(int style);
        logic [DATA_W-1:0] r;
        r = $urandom;
        if (style == 0)
            return {{13{r[18]}}, r[18:0]};
        if (style == 1)
            return r;
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            default: return r;
        endcase
    endfunction

    task automatic push_vertex(input logic mode, input logic [DATA_W-1:0] x,
                               input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] z,
                               input logic [DATA_W-1:0] w);
        vertex_t item;
        item.mode = mode;
        item.comp = {w, z, y, x};
        vertex_queue.push_back(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx < NUM_REGS)
            matrix_regs[idx] = value;
        cfg_write_count++;
    endtask

    task automatic write_matrix(input logic [CFG_DATA_W-1:0] words [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(CFG_IDX_W'(i), words[i]);
    endtask

    // Block until every queued vertex has gone in and every result came out.
    task automatic wait_for_drain();
        while (vertex_queue.size() != 0 || s_tvalid || expected_xforms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Input driver: predicts each accepted vertex and presents the next one.
    always @(posedge clk)
    begin : drive_vertices
        vertex_t seen;
        vertex_t upcoming;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                seen.mode = s_tuser;
                seen.comp = s_tdata;
                expected_xforms.push_back(transform_vertex(seen));
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (vertex_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    upcoming = vertex_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= upcoming.comp;
                    s_tuser  <= upcoming.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each result transaction with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        xform_t seen;
        xform_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.sat  = m_tuser;
                seen.comp = m_tdata;
                if (seen.sat)
                    sat_count++;
                if (expected_xforms.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result: expected none, actual %h sat %b",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_xforms.pop_front();
                    for (int k = 0; k < NUM_COMP; k++)
                        check_field(comp_names[k], want.comp[k], seen.comp[k]);
                    check_field("saturated", DATA_W'(want.sat), DATA_W'(seen.sat));
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] words [NUM_REGS];
        int style;

        // Reset state of the matrix is identity.
        matrix_regs[REG_COL0_XY] = {32'd0, Q_ONE};
        matrix_regs[REG_COL0_ZW] = '0;
        matrix_regs[REG_COL1_XY] = {Q_ONE, 32'd0};
        matrix_regs[REG_COL1_ZW] = '0;
        matrix_regs[REG_COL2_XY] = '0;
        matrix_regs[REG_COL2_ZW] = {32'd0, Q_ONE};
        matrix_regs[REG_COL3_XY] = '0;
        matrix_regs[REG_COL3_ZW] = {Q_ONE, 32'd0};
        tx_idle_pct = 13;
        rx_idle_pct = 53;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Identity matrix: extremes pass through, a point keeps w ignored.
        push_vertex(MODE_VEC4, '0, '0, '0, '0);
        push_vertex(MODE_VEC4, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vertex(MODE_VEC4, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vertex(MODE_POINT, Q_MAX, Q_MIN, Q_ONE, Q_MAX);
        push_vertex(MODE_VEC4, Q_ONE, -Q_ONE, Q_HALF, -Q_ULP);
        wait_for_drain();

        // Scale, shear and translate: clamping both ways and floor rounding.
        words[REG_COL0_XY] = {32'd0, Q_ONE << 1};
        words[REG_COL0_ZW] = {Q_HALF, 32'd0};
        words[REG_COL1_XY] = {Q_ONE, -(Q_ONE << 1)};
        words[REG_COL1_ZW] = {32'd0, Q_ONE};
        words[REG_COL2_XY] = '0;
        words[REG_COL2_ZW] = {Q_MAX, Q_ONE};
        words[REG_COL3_XY] = {-Q_ONE, Q_ONE};
        words[REG_COL3_ZW] = {Q_ONE, Q_HALF};
        write_matrix(words);
        push_vertex(MODE_VEC4, Q_MAX, '0, '0, '0);
        push_vertex(MODE_VEC4, Q_MIN, '0, '0, '0);
        push_vertex(MODE_VEC4, -Q_ULP, '0, '0, '0);
        push_vertex(MODE_POINT, '0, '0, Q_MAX, Q_MIN);
        push_vertex(MODE_VEC4, '0, '0, Q_MAX, Q_MIN);
        push_vertex(MODE_POINT, Q_MIN, Q_MAX, Q_MIN, '0);
        wait_for_drain();

        // Writes to indexes past the last register must leave the matrix alone.
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '1);
        push_vertex(MODE_VEC4, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        wait_for_drain();

        // Every element at the most negative value.
        for (int i = 0; i < NUM_REGS; i++)
            words[i] = {Q_MIN, Q_MIN};
        write_matrix(words);
        push_vertex(MODE_VEC4, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_vertex(MODE_VEC4, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_vertex(MODE_POINT, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
        wait_for_drain();

        // Alternating extremes.
        for (int i = 0; i < NUM_REGS; i++)
            words[i] = (i % 2) ? {Q_MIN, Q_MAX} : {Q_MAX, Q_MIN};
        write_matrix(words);
        push_vertex(MODE_VEC4, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_vertex(MODE_VEC4, Q_MIN, Q_MAX, Q_ULP, -Q_ULP);
        push_vertex(MODE_POINT, Q_MAX, Q_MAX, Q_MAX, '0);
        wait_for_drain();

        // Random segments, each with its own matrix; the stall pattern changes every two segments.
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            if (seg < 2)
            begin
                tx_idle_pct = 13;
                rx_idle_pct = 53;
            end
            else if (seg < 4)
            begin
                tx_idle_pct = 53;
                rx_idle_pct = 13;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            style = seg % 4;
            for (int i = 0; i < NUM_REGS; i++)
                words[i] = {rand_element(style), rand_element(style)};
            if (style == 3)
            begin
                // Identity with a random scale on the diagonal and a translation.
                words[REG_COL0_XY] = {32'd0, rand_element(0)};
                words[REG_COL0_ZW] = '0;
                words[REG_COL1_XY] = {rand_element(0), 32'd0};
                words[REG_COL1_ZW] = '0;
                words[REG_COL2_XY] = '0;
                words[REG_COL2_ZW] = {32'd0, rand_element(0)};
                words[REG_COL3_ZW] = {Q_ONE, rand_element(1)};
            end
            write_matrix(words);
            if ($urandom_range(1) == 1)
                write_reg(REG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(7)), {$urandom, $urandom});
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++)
                push_vertex(1'($urandom_range(1)), rand_component(), rand_component(),
                            rand_component(), rand_component());
            wait_for_drain();
        end

        $display("Transformed %0d vertices (%0d clamped) across %0d register writes,",
                 accepted_count, sat_count, cfg_write_count);
        $display("with random stalls on each side in turn and then an unbroken stream.");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
